FILE: src/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes of the reverse-Polish stack evaluator: token codes,
// result status codes, the operand stack entry and the divider result.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int Q_W    = 32;
  localparam int CMD_W  = 4;
  localparam int VIDX_W = 6;
  localparam int ST_W   = 3;

  // Token codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_NUM = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_VAR = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ASSIGN   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ADD      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_SUB      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MUL      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DIV      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_PRINT    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_READ     = 4'd8;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_PRINTED = 3'd1;
  localparam logic [ST_W-1:0] ST_FEW     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTVAR  = 3'd3;
  localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd5;
  localparam logic [ST_W-1:0] ST_HALTED  = 3'd6;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  // One operand stack entry: a number, or a reference to a variable slot.
  typedef struct packed {
    logic           is_ref;
    logic [Q_W-1:0] bits;
  } stk_entry_t;

  typedef struct packed {
    logic                  done;
    logic signed [Q_W-1:0] quot;
  } div_res_t;

endpackage

FILE: src/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rpn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_div
// Serial Q16.16 divider: (dividend * 65536) / divisor, truncated toward
// zero and saturated, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [rpn_pkg::Q_W-1:0] dividend,
  input  logic signed [rpn_pkg::Q_W-1:0] divisor,
  output rpn_pkg::div_res_t             res
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } dstate_t;

  dstate_t     dstate_r, dstate_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] mb_r, mb_nxt;
  logic        neg_r, neg_nxt;
  logic        sat_r, sat_nxt;

  logic [31:0] ma, mb;
  logic        too_big;
  logic [32:0] trial, diff;
  logic        ge;

  assign ma      = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign mb      = divisor[31] ? (~divisor + 32'd1) : divisor;
  // The quotient needs more than 32 bits exactly when |a| >= |b| * 65536.
  assign too_big = {16'd0, ma} >= {mb, 16'd0};
  assign trial   = {rem_r, dvd_r[31]};
  assign diff    = trial - {1'b0, mb_r};
  assign ge      = trial >= {1'b0, mb_r};

  always_comb begin
    dstate_nxt = dstate_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    mb_nxt     = mb_r;
    neg_nxt    = neg_r;
    sat_nxt    = sat_r;
    unique case (dstate_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt = dividend[31] ^ divisor[31];
          sat_nxt = too_big;
          mb_nxt  = mb;
          rem_nxt = {16'd0, ma[31:16]};
          dvd_nxt = {ma[15:0], 16'd0};
          quo_nxt = '0;
          cnt_nxt = '0;
          dstate_nxt = too_big ? D_DONE : D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff[31:0] : trial[31:0];
        quo_nxt = {quo_r[30:0], ge};
        dvd_nxt = {dvd_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          dstate_nxt = D_DONE;
        end
      end
      D_DONE: begin
        dstate_nxt = D_IDLE;
      end
      default: begin
        dstate_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
    end else begin
      dstate_r <= dstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
  end

  always_comb begin
    res.done = (dstate_r == D_DONE);
    if (sat_r) begin
      res.quot = neg_r ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
    end else if (!neg_r) begin
      res.quot = quo_r[31] ? rpn_pkg::Q_MAX : quo_r;
    end else begin
      res.quot = (quo_r > 32'h8000_0000) ? rpn_pkg::Q_MIN : (~quo_r + 32'd1);
    end
  end

endmodule

FILE: src/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// Pushes, unused codes, halted tokens and missing operands go straight to S_RESP. Add, sub,
// mul, div, assign, print and read pass S_TOP, S_NEXT and S_OPND, then S_EXEC; mul adds
// S_MUL, and a divide with a nonzero divisor waits in S_DIV on the serial divider, one
// quotient bit per cycle. One token is worked at a time; the next is taken the cycle after
// its result is registered. After reset the variable table is cleared one slot per cycle,
// with no token taken; the stack is empty and the halt flag clear.
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Reverse-Polish evaluator with the operand stack and the variable table in
// synchronous RAMs; Q16.16 saturating arithmetic; halts on the first error.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int VAR_COUNT   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] literal_value, [37:32] var_index, rest zero
  input  logic [3:0]  in_tuser,   // [3:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] printed_value
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_TOP   = 9'b000000100,
    S_NEXT  = 9'b000001000,
    S_OPND  = 9'b000010000,
    S_EXEC  = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

  // Slot index reduced modulo VAR_COUNT, one bit of the index per step.
  function automatic logic [VW-1:0] wrap_idx(input logic [rpn_pkg::VIDX_W-1:0] v);
    logic [VW:0] r;
    r = '0;
    for (int i = rpn_pkg::VIDX_W - 1; i >= 0; i--) begin
      r = {r[VW-1:0], v[i]};
      if (r >= (VW+1)'(VAR_COUNT)) begin
        r = r - (VW+1)'(VAR_COUNT);
      end
    end
    return r[VW-1:0];
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v[63:31] == '0 || v[63:31] == '1) begin
      return v[31:0];
    end
    return v[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
  endfunction

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              sc_r, sc_nxt;
  logic                       halted_r, halted_nxt;
  logic [VW-1:0]              clr_r, clr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [2:0]                 out_user_r, out_user_nxt;
  logic [31:0]                out_data_r, out_data_nxt;
  logic [3:0]                 cmd_r, cmd_nxt;
  logic signed [31:0]         lit_r, lit_nxt;
  rpn_pkg::stk_entry_t        a_r, a_nxt;
  rpn_pkg::stk_entry_t        b_r, b_nxt;
  logic signed [31:0]         bval_r, bval_nxt;
  logic signed [63:0]         prod_r, prod_nxt;
  logic [2:0]                 st_r, st_nxt;
  logic [31:0]                pv_r, pv_nxt;

  logic                       in_acc;
  logic [3:0]                 in_cmd;
  logic signed [31:0]         in_lit;
  logic [rpn_pkg::VIDX_W-1:0] in_vidx;
  logic [CW-1:0]              sc_m1, sc_m2;
  logic [AW-1:0]              tos_addr, nos_addr;
  logic signed [31:0]         aval;
  logic [32:0]                sum33, dif33;

  logic                       stk_we;
  logic [AW-1:0]              stk_waddr, stk_raddr;
  rpn_pkg::stk_entry_t        stk_wdata, stk_rdata;
  logic                       var_we;
  logic [VW-1:0]              var_waddr, var_raddr;
  logic [31:0]                var_wdata, var_rdata;
  logic                       div_start;
  rpn_pkg::div_res_t          div_res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign in_cmd     = in_tuser;
  assign in_lit     = in_tdata[31:0];
  assign in_vidx    = in_tdata[37:32];
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

  assign sc_m1    = sc_r - CW'(1);
  assign sc_m2    = sc_r - CW'(2);
  assign tos_addr = sc_m1[AW-1:0];
  assign nos_addr = sc_m2[AW-1:0];
  assign aval     = a_r.is_ref ? var_rdata : a_r.bits;
  assign sum33    = {aval[31], aval} + {bval_r[31], bval_r};
  assign dif33    = {aval[31], aval} - {bval_r[31], bval_r};

  // Both entries come from the stack RAM in turn, the top first, so the slot
  // read follows the stack read data directly.
  assign stk_raddr = (state_r == S_TOP) ? tos_addr : nos_addr;
  assign var_raddr = stk_rdata.bits[VW-1:0];

  always_comb begin
    state_nxt     = state_r;
    sc_nxt        = sc_r;
    halted_nxt    = halted_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    lit_nxt       = lit_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    bval_nxt      = bval_r;
    prod_nxt      = prod_r;
    st_nxt        = st_r;
    pv_nxt        = pv_r;
    stk_we        = 1'b0;
    stk_waddr     = nos_addr;
    stk_wdata     = '0;
    var_we        = 1'b0;
    var_waddr     = clr_r;
    var_wdata     = '0;
    div_start     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        var_we  = 1'b1;
        clr_nxt = clr_r + VW'(1);
        if (clr_r == VW'(VAR_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_cmd;
          lit_nxt   = in_lit;
          st_nxt    = rpn_pkg::ST_OK;
          pv_nxt    = '0;
          state_nxt = S_RESP;
          if (halted_r) begin
            st_nxt = rpn_pkg::ST_HALTED;
          end else begin
            case (in_cmd) inside
              rpn_pkg::CMD_PUSH_NUM, rpn_pkg::CMD_PUSH_VAR: begin
                if (sc_r == CW'(STACK_DEPTH)) begin
                  st_nxt     = rpn_pkg::ST_FULL;
                  halted_nxt = 1'b1;
                end else begin
                  stk_we           = 1'b1;
                  stk_waddr        = sc_r[AW-1:0];
                  stk_wdata.is_ref = (in_cmd == rpn_pkg::CMD_PUSH_VAR);
                  stk_wdata.bits   = (in_cmd == rpn_pkg::CMD_PUSH_VAR)
                                     ? 32'(wrap_idx(in_vidx)) : in_lit;
                  sc_nxt           = sc_r + CW'(1);
                end
              end
              rpn_pkg::CMD_ASSIGN, rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
              rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
                if (sc_r < CW'(2)) begin
                  st_nxt     = rpn_pkg::ST_FEW;
                  halted_nxt = 1'b1;
                end else begin
                  state_nxt = S_TOP;
                end
              end
              rpn_pkg::CMD_PRINT, rpn_pkg::CMD_READ: begin
                if (sc_r == '0) begin
                  st_nxt     = rpn_pkg::ST_FEW;
                  halted_nxt = 1'b1;
                end else begin
                  state_nxt = S_TOP;
                end
              end
              default: begin
                st_nxt = rpn_pkg::ST_OK;
              end
            endcase
          end
        end
      end
      S_TOP: begin
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        b_nxt     = stk_rdata;
        state_nxt = S_OPND;
      end
      S_OPND: begin
        bval_nxt  = b_r.is_ref ? var_rdata : b_r.bits;
        a_nxt     = stk_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        case (cmd_r) inside
          rpn_pkg::CMD_ASSIGN: begin
            if (!a_r.is_ref) begin
              st_nxt     = rpn_pkg::ST_NOTVAR;
              halted_nxt = 1'b1;
            end else begin
              var_we    = 1'b1;
              var_waddr = a_r.bits[VW-1:0];
              var_wdata = bval_r;
              sc_nxt    = sc_m2;
            end
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
            stk_we = 1'b1;
            if (cmd_r == rpn_pkg::CMD_ADD) begin
              stk_wdata.bits = (sum33[32] ^ sum33[31])
                ? (sum33[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX) : sum33[31:0];
            end else begin
              stk_wdata.bits = (dif33[32] ^ dif33[31])
                ? (dif33[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX) : dif33[31:0];
            end
            sc_nxt = sc_m1;
          end
          rpn_pkg::CMD_MUL: begin
            prod_nxt  = aval * bval_r;
            state_nxt = S_MUL;
          end
          rpn_pkg::CMD_DIV: begin
            if (bval_r == '0) begin
              st_nxt     = rpn_pkg::ST_DIVZERO;
              halted_nxt = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          rpn_pkg::CMD_PRINT: begin
            st_nxt = rpn_pkg::ST_PRINTED;
            pv_nxt = bval_r;
            sc_nxt = sc_m1;
          end
          rpn_pkg::CMD_READ: begin
            if (!b_r.is_ref) begin
              st_nxt     = rpn_pkg::ST_NOTVAR;
              halted_nxt = 1'b1;
            end else begin
              var_we    = 1'b1;
              var_waddr = b_r.bits[VW-1:0];
              var_wdata = lit_r;
              sc_nxt    = sc_m1;
            end
          end
          default: begin
            st_nxt = rpn_pkg::ST_OK;
          end
        endcase
      end
      S_MUL: begin
        // The arithmetic shift rounds the product toward minus infinity.
        stk_we         = 1'b1;
        stk_wdata.bits = sat64(prod_r >>> 16);
        sc_nxt         = sc_m1;
        state_nxt      = S_RESP;
      end
      S_DIV: begin
        if (div_res.done) begin
          stk_we         = 1'b1;
          stk_wdata.bits = div_res.quot;
          sc_nxt         = sc_m1;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = st_r;
          out_data_nxt  = pv_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sc_r        <= '0;
      halted_r    <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      halted_r    <= halted_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
    cmd_r      <= cmd_nxt;
    lit_r      <= lit_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    bval_r     <= bval_nxt;
    prod_r     <= prod_nxt;
    st_r       <= st_nxt;
    pv_r       <= pv_nxt;
  end

  rpn_ram #(
    .WIDTH ($bits(rpn_pkg::stk_entry_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  rpn_ram #(
    .WIDTH (rpn_pkg::Q_W),
    .DEPTH (VAR_COUNT)
  ) u_var_ram (
    .clk   (clk),
    .we    (var_we),
    .waddr (var_waddr),
    .wdata (var_wdata),
    .raddr (var_raddr),
    .rdata (var_rdata)
  );

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (aval),
    .divisor  (bval_r),
    .res      (div_res)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= CW'(STACK_DEPTH))
    else $error("operand count beyond stack depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped without reset");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (sc_r != $past(sc_r)) |-> ((sc_r == $past(sc_r) + CW'(1)) ||
                               (sc_r == $past(sc_r) - CW'(1)) ||
                               (sc_r == $past(sc_r) - CW'(2))))
    else $error("operand count moved by an impossible step");

  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r != rpn_pkg::ST_PRINTED) |-> (out_data_r == '0))
    else $error("nonzero value in a result that is not a print");
`endif

endmodule

FILE: tb/rpn_stack_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_tb
// Self-checking bench for the reverse-Polish evaluator. Tokens are sent over
// the input stream in random bursts. A local model of the stack, variables
// and halt flag predicts each status and printed value. Every result transfer
// is compared in order. The run covers directed saturation and rounding cases,
// variable access, output back-pressure and random well-formed expressions.
// It ends on one randomly chosen error that halts the block.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_tb;

  localparam int STACK_DEPTH   = 16;
  localparam int VAR_COUNT     = 64;
  localparam int RANDOM_TOKENS = 860;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 50;

  localparam logic [rpn_pkg::CMD_W-1:0] CMD_FIRST_UNUSED = 4'd9;
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_LAST_UNUSED  = 4'd15;

  typedef struct {
    logic [rpn_pkg::ST_W-1:0]       status;
    logic signed [rpn_pkg::Q_W-1:0] printed;
  } token_result_t;

  typedef enum {HALT_FEW, HALT_NOTVAR, HALT_DIVZERO, HALT_FULL} halt_path_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // [31:0] literal_value, [37:32] var_index, rest zero
  logic [3:0]  in_tuser = '0;   // [3:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] printed_value
  logic [2:0]  out_tuser;       // [2:0] status

  // Model state of the evaluator.
  rpn_pkg::stk_entry_t            opstack [STACK_DEPTH];
  int                             stack_len = 0;
  logic signed [rpn_pkg::Q_W-1:0] var_slots [VAR_COUNT];
  bit                             halted_flag = 1'b0;

  token_result_t pending_results [$];
  int            error_count = 0;
  int            tokens_sent = 0;
  int            results_checked = 0;
  int            burst_left = 0;
  int            idle_cycles = 0;
  bit            hold_req = 1'b0;
  halt_path_t    ended_on = HALT_FEW;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH),
    .VAR_COUNT  (VAR_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (var_slots[i]) var_slots[i] = '0;
  end

  // ---------------------------------------------------------------- model --

  function automatic longint entry_value(rpn_pkg::stk_entry_t e);
    if (e.is_ref) return longint'(var_slots[e.bits % VAR_COUNT]);
    return longint'(signed'(e.bits));
  endfunction

  function automatic logic signed [rpn_pkg::Q_W-1:0] clamp_q(longint v);
    if (v > longint'(rpn_pkg::Q_MAX)) return rpn_pkg::Q_MAX;
    if (v < longint'(rpn_pkg::Q_MIN)) return rpn_pkg::Q_MIN;
    return (rpn_pkg::Q_W)'(v);
  endfunction

  function automatic token_result_t eval_token(logic [rpn_pkg::CMD_W-1:0] cmd,
                                               logic signed [rpn_pkg::Q_W-1:0] lit,
                                               logic [rpn_pkg::VIDX_W-1:0] slot);
    token_result_t                  res;
    longint                         lv;
    longint                         rv;
    logic signed [rpn_pkg::Q_W-1:0] num;
    res.status  = rpn_pkg::ST_OK;
    res.printed = '0;
    if (halted_flag) begin
      res.status = rpn_pkg::ST_HALTED;
      return res;
    end
    case (cmd) inside
      rpn_pkg::CMD_PUSH_NUM, rpn_pkg::CMD_PUSH_VAR: begin
        if (stack_len >= STACK_DEPTH) begin
          res.status = rpn_pkg::ST_FULL;
        end else begin
          opstack[stack_len].is_ref = (cmd == rpn_pkg::CMD_PUSH_VAR);
          opstack[stack_len].bits   = (cmd == rpn_pkg::CMD_PUSH_VAR)
                                      ? (rpn_pkg::Q_W)'(slot % VAR_COUNT) : lit;
          stack_len++;
        end
      end
      rpn_pkg::CMD_ASSIGN: begin
        if (stack_len < 2) begin
          res.status = rpn_pkg::ST_FEW;
        end else if (!opstack[stack_len-2].is_ref) begin
          res.status = rpn_pkg::ST_NOTVAR;
        end else begin
          var_slots[opstack[stack_len-2].bits % VAR_COUNT] =
            (rpn_pkg::Q_W)'(entry_value(opstack[stack_len-1]));
          stack_len -= 2;
        end
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (stack_len < 2) begin
          res.status = rpn_pkg::ST_FEW;
        end else begin
          rv = entry_value(opstack[stack_len-1]);
          lv = entry_value(opstack[stack_len-2]);
          if (cmd == rpn_pkg::CMD_DIV && rv == 0) begin
            res.status = rpn_pkg::ST_DIVZERO;
          end else begin
            case (cmd)
              rpn_pkg::CMD_ADD: num = clamp_q(lv + rv);
              rpn_pkg::CMD_SUB: num = clamp_q(lv - rv);
              // Arithmetic shift of the product floors toward minus infinity.
              rpn_pkg::CMD_MUL: num = clamp_q((lv * rv) >>> 16);
              default: num = clamp_q((lv * 65536) / rv);
            endcase
            stack_len -= 1;
            opstack[stack_len-1].is_ref = 1'b0;
            opstack[stack_len-1].bits   = num;
          end
        end
      end
      rpn_pkg::CMD_PRINT: begin
        if (stack_len < 1) begin
          res.status = rpn_pkg::ST_FEW;
        end else begin
          res.printed = (rpn_pkg::Q_W)'(entry_value(opstack[stack_len-1]));
          res.status  = rpn_pkg::ST_PRINTED;
          stack_len--;
        end
      end
      rpn_pkg::CMD_READ: begin
        if (stack_len < 1) begin
          res.status = rpn_pkg::ST_FEW;
        end else if (!opstack[stack_len-1].is_ref) begin
          res.status = rpn_pkg::ST_NOTVAR;
        end else begin
          var_slots[opstack[stack_len-1].bits % VAR_COUNT] = lit;
          stack_len--;
        end
      end
      default: ;
    endcase
    if (res.status != rpn_pkg::ST_OK && res.status != rpn_pkg::ST_PRINTED) halted_flag = 1'b1;
    return res;
  endfunction

  // True when the token cannot raise an error in the current model state.
  function automatic bit token_is_safe(logic [rpn_pkg::CMD_W-1:0] cmd);
    case (cmd) inside
      rpn_pkg::CMD_PUSH_NUM, rpn_pkg::CMD_PUSH_VAR: return stack_len < STACK_DEPTH;
      rpn_pkg::CMD_ASSIGN: return stack_len >= 2 && opstack[stack_len-2].is_ref;
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: return stack_len >= 2;
      rpn_pkg::CMD_DIV: return stack_len >= 2 && entry_value(opstack[stack_len-1]) != 0;
      rpn_pkg::CMD_PRINT: return stack_len >= 1;
      rpn_pkg::CMD_READ: return stack_len >= 1 && opstack[stack_len-1].is_ref;
      default: return 1'b1;
    endcase
  endfunction

  // ------------------------------------------------------------ stimulus --

  function automatic logic signed [rpn_pkg::Q_W-1:0] rand_q();
    case ($urandom_range(0, 7)) inside
      0: return rpn_pkg::Q_MAX;
      1: return rpn_pkg::Q_MIN;
      2: return (rpn_pkg::Q_W)'($urandom_range(0, 4)) - 32'sd2;
      3, 4: return $urandom();
      default: return (rpn_pkg::Q_W)'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [rpn_pkg::VIDX_W-1:0] rand_slot();
    if ($urandom_range(0, 3) == 0) begin
      return (rpn_pkg::VIDX_W)'($urandom_range(0, VAR_COUNT - 1));
    end
    return (rpn_pkg::VIDX_W)'($urandom_range(0, 7));
  endfunction

  function automatic logic [rpn_pkg::CMD_W-1:0] rand_safe_cmd();
    logic [rpn_pkg::CMD_W-1:0] cmd;
    do cmd = (rpn_pkg::CMD_W)'($urandom_range(rpn_pkg::CMD_PUSH_NUM, rpn_pkg::CMD_READ));
    while (!token_is_safe(cmd));
    return cmd;
  endfunction

  function automatic logic [rpn_pkg::CMD_W-1:0] rand_arith_cmd();
    case ($urandom_range(0, 2))
      0: return rpn_pkg::CMD_ADD;
      1: return rpn_pkg::CMD_SUB;
      default: return rpn_pkg::CMD_MUL;
    endcase
  endfunction

  // Offers one token, waits for its transfer, records the prediction, and
  // idles between bursts.
  task automatic send_token(input logic [rpn_pkg::CMD_W-1:0] cmd,
                            input logic signed [rpn_pkg::Q_W-1:0] lit,
                            input logic [rpn_pkg::VIDX_W-1:0] slot);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, slot, lit};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_results.push_back(eval_token(cmd, lit, slot));
    tokens_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 45) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_saturating_add_sub();
    send_token(rpn_pkg::CMD_PUSH_NUM, rpn_pkg::Q_MAX, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, 32'sd1, '0);
    send_token(rpn_pkg::CMD_ADD, '0, '0);
    send_token(rpn_pkg::CMD_PRINT, '0, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, rpn_pkg::Q_MIN, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, 32'sd1, '0);
    send_token(rpn_pkg::CMD_SUB, '0, '0);
    send_token(rpn_pkg::CMD_PRINT, '0, '0);
  endtask

  task automatic test_mul_div_rounding();
    // A tiny negative product must round down, not toward zero.
    send_token(rpn_pkg::CMD_PUSH_NUM, -32'sd1, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, 32'sd3, '0);
    send_token(rpn_pkg::CMD_MUL, '0, '0);
    send_token(rpn_pkg::CMD_PRINT, '0, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, rpn_pkg::Q_MIN, '0);
    send_token(rpn_pkg::CMD_PUSH_NUM, -32'sd1, '0);
    send_token(rpn_pkg::CMD_DIV, '0, '0);
    send_token(rpn_pkg::CMD_PRINT, '0, '0);
  endtask

  task automatic test_variables();
    send_token(rpn_pkg::CMD_PUSH_VAR, '0, 6'd0);
    send_token(rpn_pkg::CMD_READ, rpn_pkg::Q_MAX, '0);
    send_token(rpn_pkg::CMD_PUSH_VAR, '0, 6'd63);
    send_token(rpn_pkg::CMD_PUSH_VAR, '0, 6'd0);
    send_token(rpn_pkg::CMD_ASSIGN, '0, '0);
    send_token(rpn_pkg::CMD_PUSH_VAR, '0, 6'd63);
    send_token(rpn_pkg::CMD_PRINT, '0, '0);
  endtask

  task automatic test_unused_codes();
    send_token(CMD_FIRST_UNUSED, rpn_pkg::Q_MIN, 6'd63);
    send_token(CMD_LAST_UNUSED, rpn_pkg::Q_MAX, 6'd0);
  endtask

  task automatic test_output_holdoff();
    hold_req = 1'b1;
    repeat (12) send_token(rand_safe_cmd(), rand_q(), rand_slot());
    wait (!hold_req);
    wait_drained();
  endtask

  task automatic test_random_tokens(input int target);
    int done_tokens;
    int pick;
    done_tokens = 0;
    while (done_tokens < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_token((rpn_pkg::CMD_W)'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)),
                   rand_q(), rand_slot());
      end else if (pick <= 4 && stack_len <= STACK_DEPTH - 3) begin
        // Assignment statement: target reference, an expression, then assign.
        send_token(rpn_pkg::CMD_PUSH_VAR, rand_q(), rand_slot());
        send_token(($urandom_range(0, 2) == 0) ? rpn_pkg::CMD_PUSH_VAR : rpn_pkg::CMD_PUSH_NUM,
                   rand_q(), rand_slot());
        if ($urandom_range(0, 1) == 1) begin
          send_token(rpn_pkg::CMD_PUSH_NUM, rand_q(), rand_slot());
          send_token(rand_arith_cmd(), rand_q(), rand_slot());
          done_tokens += 2;
        end
        send_token(rpn_pkg::CMD_ASSIGN, rand_q(), rand_slot());
        done_tokens += 3;
      end else if (pick <= 6 && stack_len < STACK_DEPTH) begin
        send_token(rpn_pkg::CMD_PUSH_VAR, rand_q(), rand_slot());
        send_token(rpn_pkg::CMD_READ, rand_q(), rand_slot());
        done_tokens += 2;
      end else begin
        send_token(rand_safe_cmd(), rand_q(), rand_slot());
        done_tokens++;
      end
      if (pick == 19 && $urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Ends the run's useful work: one error, then tokens that must be refused.
  task automatic test_error_halt();
    while (stack_len > 0) send_token(rpn_pkg::CMD_PRINT, rand_q(), rand_slot());
    ended_on = halt_path_t'($urandom_range(0, 3));
    case (ended_on)
      HALT_FEW: begin
        if ($urandom_range(0, 1) == 1) begin
          send_token(rpn_pkg::CMD_PUSH_NUM, rand_q(), rand_slot());
          send_token((rpn_pkg::CMD_W)'($urandom_range(rpn_pkg::CMD_ASSIGN, rpn_pkg::CMD_DIV)),
                     rand_q(), rand_slot());
        end else begin
          send_token((rpn_pkg::CMD_W)'($urandom_range(rpn_pkg::CMD_ASSIGN, rpn_pkg::CMD_READ)),
                     rand_q(), rand_slot());
        end
      end
      HALT_NOTVAR: begin
        send_token(rpn_pkg::CMD_PUSH_NUM, rand_q(), rand_slot());
        if ($urandom_range(0, 1) == 1) begin
          send_token(rpn_pkg::CMD_PUSH_VAR, rand_q(), rand_slot());
          send_token(rpn_pkg::CMD_ASSIGN, rand_q(), rand_slot());
        end else begin
          send_token(rpn_pkg::CMD_READ, rand_q(), rand_slot());
        end
      end
      HALT_DIVZERO: begin
        send_token(rpn_pkg::CMD_PUSH_NUM, rand_q(), rand_slot());
        send_token(rpn_pkg::CMD_PUSH_NUM, '0, rand_slot());
        send_token(rpn_pkg::CMD_DIV, rand_q(), rand_slot());
      end
      default: begin
        repeat (STACK_DEPTH + 1)
          send_token(($urandom_range(0, 1) == 1) ? rpn_pkg::CMD_PUSH_VAR
                                                 : rpn_pkg::CMD_PUSH_NUM,
                     rand_q(), rand_slot());
      end
    endcase
    repeat (6) send_token((rpn_pkg::CMD_W)'($urandom_range(0, CMD_LAST_UNUSED)), rand_q(),
                          rand_slot());
  endtask

  // ------------------------------------------------------------ receiver --

  initial begin : receiver
    int seg_left;
    int stall_pct;
    seg_left  = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 150);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------- checking --

  always @(posedge clk) begin : result_check
    token_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: unexpected result transfer, status %0d value %h",
                   $realtime, out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status || out_tdata !== want.printed) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: mismatch, status exp %0d got %0d, value exp %h got %h",
                     $realtime, want.status, out_tuser, want.printed, out_tdata);
        end
      end
    end
  end

  // Ends a hung run: no transfer on either side for too long.
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence --

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_saturating_add_sub();
    test_mul_div_rounding();
    test_variables();
    test_unused_codes();
    test_output_holdoff();
    test_random_tokens(RANDOM_TOKENS);
    test_error_halt();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += pending_results.size();
    $display("Sent %0d tokens and checked %0d results: saturation, rounding, variables,",
             tokens_sent, results_checked);
    $display("back-pressure and random expressions, ending on the %s halt path.",
             ended_on.name());
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
